/* rtl/core/negative_cycle_reach_marking_top_defines.svh */
// Assertion macros for the shortest path block
`ifndef NEGATIVE_CYCLE_REACH_MARKING_TOP_DEFINES_SVH
`define NEGATIVE_CYCLE_REACH_MARKING_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

/* rtl/core/ncrm_pkg.sv */
`timescale 1ns / 1ps
package ncrm_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int DEF_COST_BITS    = 16;

    localparam int VTX_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;

    localparam logic [CFG_IDX_BITS-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SOURCE       = 2'd1;

    localparam logic RES_RUN  = 1'b0;
    localparam logic RES_READ = 1'b1;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_CLEAR = 2'd1,
        K_RUN   = 2'd2,
        K_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_RSTART,
        S_FETCH,
        S_VREAD,
        S_RELAX,
        S_PEND,
        S_DONE
    } t_state;

endpackage

/* rtl/core/negative_cycle_reach_marking_top.sv */
`timescale 1ns / 1ps
// Add and clear items: one per cycle while idle, no result. Read item: result registered in
// S_QUERY, which follows acceptance; input stalls there, so a new read waits until it is left.
// Run item: start state, then S_FETCH, S_VREAD and S_RELAX per edge (a read-modify-write of
// the distance memory), S_FETCH and S_PEND at each pass end, up to 2*V passes, finish state.
// Input stalls for the whole run and, for run and read items, while a result beat waits.
// Synchronous active-low reset clears edge count, flags, reach/mark bits and source; vertex count to 1.
`include "negative_cycle_reach_marking_top_defines.svh"
module negative_cycle_reach_marking_top
    import ncrm_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = DEF_MAX_EDGES,
    parameter int COST_BITS    = DEF_COST_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic [VTX_BITS-1:0]      i_from_vertex,
    input  logic [VTX_BITS-1:0]      i_to_vertex,
    input  logic signed [15:0]       i_edge_cost,
    input  logic [VTX_BITS-1:0]      i_query_vertex,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_result_kind,
    output logic                     o_cycle_found,
    output logic                     o_edges_dropped,
    output logic signed [31:0]       o_distance,
    output logic                     o_reachable,
    output logic                     o_affected
);
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int TW = $clog2(MAX_EDGES + 1);
    localparam int XW = ((VW > VTX_BITS) ? VW : VTX_BITS) + 1;
    localparam logic [XW-1:0] MAXV = XW'(MAX_VERTICES);
    localparam logic [TW-1:0] MAXE = TW'(MAX_EDGES);

    t_state r_state, n_state;
    t_kind  w_kind;

    logic [6:0]              r_vcount;
    logic [VTX_BITS-1:0]     r_src;
    logic [TW-1:0]           r_total;
    logic                    r_ovf, r_cycle;
    logic [MAX_VERTICES-1:0] r_reached, r_affected;
    logic [XW-1:0]           r_n, r_pass;
    logic                    r_mark, r_changed;
    logic [TW-1:0]           r_eidx;
    logic [XW-1:0]           r_q;

    logic r_out_valid, r_res_kind, r_res_cycle, r_res_ovf, r_res_reach, r_res_aff;
    logic signed [31:0] r_res_dist;

    logic w_accept;
    logic w_edge_we, w_edge_re;
    logic [VTX_BITS-1:0] w_e_tail, w_e_head;
    logic signed [COST_BITS-1:0] w_e_cost;
    logic signed [31:0] w_cost32;

    logic w_d_we, w_d_re_a, w_d_re_b;
    logic [VW-1:0] w_d_waddr, w_d_addr_a, w_d_addr_b;
    logic signed [31:0] w_d_wdata, w_d_a, w_d_b;

    logic [XW-1:0] w_vcx, w_neff, w_fx, w_tx, w_srcx;
    logic [VW-1:0] w_fi, w_ti;
    logic          w_edge_ok, w_upd, w_qok;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_cand;

    assign w_kind   = t_kind'(i_kind);
    assign w_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) ||
        (r_out_valid && i_out_stall && (w_kind == K_RUN || w_kind == K_READ));

    assign w_cost32 = 32'(i_edge_cost);

    ncrm_edge_mem #(.MAX_EDGES(MAX_EDGES), .COST_BITS(COST_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (r_total[EW-1:0]),
        .i_wtail (i_from_vertex),
        .i_whead (i_to_vertex),
        .i_wcost (signed'(w_cost32[COST_BITS-1:0])),
        .i_re    (w_edge_re),
        .i_raddr (r_eidx[EW-1:0]),
        .o_tail  (w_e_tail),
        .o_head  (w_e_head),
        .o_cost  (w_e_cost)
    );

    ncrm_dist_mem #(.MAX_VERTICES(MAX_VERTICES)) u_dist (
        .i_clk    (i_clk),
        .i_we     (w_d_we),
        .i_waddr  (w_d_waddr),
        .i_wdata  (w_d_wdata),
        .i_re_a   (w_d_re_a),
        .i_addr_a (w_d_addr_a),
        .o_data_a (w_d_a),
        .i_re_b   (w_d_re_b),
        .i_addr_b (w_d_addr_b),
        .o_data_b (w_d_b)
    );

    // effective vertex count, endpoints and relaxation
    always_comb begin
        w_vcx  = XW'(r_vcount);
        w_neff = (w_vcx == '0) ? XW'(1) : ((w_vcx > MAXV) ? MAXV : w_vcx);
        w_srcx = XW'(r_src);
        w_fx   = XW'(w_e_tail);
        w_tx   = XW'(w_e_head);
        w_fi   = w_fx[VW-1:0];
        w_ti   = w_tx[VW-1:0];
        w_edge_ok = (w_fx < r_n) && (w_tx < r_n) && r_reached[w_fi];
        w_sum  = 33'(w_d_a) + 33'(w_e_cost);
        if (w_sum[32] != w_sum[31]) begin
            w_cand = w_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            w_cand = w_sum[31:0];
        end
        w_upd = w_edge_ok && (!r_reached[w_ti] || (w_cand < w_d_b));
        w_qok = r_q < MAXV;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_kind == K_RUN) n_state = S_RSTART;
                else if (w_accept && w_kind == K_READ) n_state = S_QUERY;
            end
            S_QUERY:  n_state = S_IDLE;
            S_RSTART: n_state = (w_srcx >= r_n) ? S_DONE : S_FETCH;
            S_FETCH:  n_state = (r_eidx == r_total) ? S_PEND : S_VREAD;
            S_VREAD:  n_state = S_RELAX;
            S_RELAX:  n_state = S_FETCH;
            S_PEND: begin
                if (!r_mark) n_state = r_changed ? S_FETCH : S_DONE;
                else n_state = (r_pass + XW'(1) == r_n) ? S_DONE : S_FETCH;
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_edge_we  = 1'b0;
        w_edge_re  = 1'b0;
        w_d_we     = 1'b0;
        w_d_waddr  = w_ti;
        w_d_wdata  = w_cand;
        w_d_re_a   = 1'b0;
        w_d_re_b   = 1'b0;
        w_d_addr_a = w_fi;
        w_d_addr_b = w_ti;
        unique case (r_state)
            S_IDLE: begin
                w_edge_we  = w_accept && w_kind == K_ADD && r_total < MAXE;
                w_d_re_a   = w_accept && w_kind == K_READ;
                w_d_addr_a = VW'(XW'(i_query_vertex));
            end
            S_RSTART: begin
                w_d_we    = w_srcx < r_n;
                w_d_waddr = w_srcx[VW-1:0];
                w_d_wdata = '0;
            end
            S_FETCH:  w_edge_re = r_eidx != r_total;
            S_VREAD: begin
                w_d_re_a = 1'b1;
                w_d_re_b = 1'b1;
            end
            S_RELAX:  w_d_we = w_upd;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= 7'd1;
            r_src       <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_cycle     <= 1'b0;
            r_reached   <= '0;
            r_affected  <= '0;
            r_mark      <= 1'b0;
            r_changed   <= 1'b0;
            r_pass      <= '0;
            r_eidx      <= '0;
            r_n         <= XW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == CFG_VERTEX_COUNT) r_vcount <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_SOURCE) r_src <= i_cfg_data[VTX_BITS-1:0];
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_kind)
                            K_ADD: begin
                                if (r_total < MAXE) r_total <= r_total + TW'(1);
                                else r_ovf <= 1'b1;
                            end
                            K_CLEAR: begin
                                r_total <= '0;
                                r_ovf   <= 1'b0;
                            end
                            K_RUN: begin
                                r_n        <= w_neff;
                                r_reached  <= '0;
                                r_affected <= '0;
                                r_cycle    <= 1'b0;
                                r_mark     <= 1'b0;
                            end
                            K_READ: r_q <= XW'(i_query_vertex);
                            default: ;
                        endcase
                    end
                end
                S_QUERY: begin
                    r_out_valid <= 1'b1;
                    r_res_kind  <= RES_READ;
                    r_res_cycle <= r_cycle;
                    r_res_ovf   <= r_ovf;
                    r_res_reach <= w_qok && r_reached[r_q[VW-1:0]];
                    r_res_aff   <= w_qok && r_affected[r_q[VW-1:0]];
                    r_res_dist  <= (w_qok && r_reached[r_q[VW-1:0]]) ? w_d_a : '0;
                end
                S_RSTART: begin
                    if (w_srcx < r_n) r_reached[w_srcx[VW-1:0]] <= 1'b1;
                    r_pass    <= '0;
                    r_mark    <= 1'b0;
                    r_changed <= 1'b0;
                    r_eidx    <= '0;
                end
                S_FETCH: begin
                    if (r_eidx != r_total) r_eidx <= r_eidx + TW'(1);
                end
                S_RELAX: begin
                    if (w_upd) begin
                        r_reached[w_ti] <= 1'b1;
                        r_changed       <= 1'b1;
                    end
                    // mark improved heads and spread downstream of an affected tail
                    if (r_mark && (w_upd || (w_edge_ok && r_affected[w_fi])))
                        r_affected[w_ti] <= 1'b1;
                end
                S_PEND: begin
                    r_eidx    <= '0;
                    r_changed <= 1'b0;
                    if (!r_mark && r_changed && r_pass + XW'(1) == r_n) begin
                        r_cycle <= 1'b1;
                        r_mark  <= 1'b1;
                        r_pass  <= '0;
                    end else begin
                        r_pass <= r_pass + XW'(1);
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_res_kind  <= RES_RUN;
                    r_res_cycle <= r_cycle;
                    r_res_ovf   <= r_ovf;
                    r_res_reach <= 1'b0;
                    r_res_aff   <= 1'b0;
                    r_res_dist  <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_res_kind;
    assign o_cycle_found   = r_res_cycle;
    assign o_edges_dropped = r_res_ovf;
    assign o_distance      = r_res_dist;
    assign o_reachable     = r_res_reach;
    assign o_affected      = r_res_aff;

    `ASSERT_NEXT(a_run_starts, i_clk, i_rst_n, w_accept && w_kind == K_RUN, r_state == S_RSTART)
    `ASSERT_SAME(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= MAXE)
    `ASSERT_SAME(a_mark_needs_cycle, i_clk, i_rst_n, r_mark, r_cycle)
    `ASSERT_SAME(a_out_source, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state == S_QUERY || r_state == S_DONE))
endmodule

/* rtl/core/ncrm_edge_mem.sv */
`timescale 1ns / 1ps
module ncrm_edge_mem
    import ncrm_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    parameter int COST_BITS = DEF_COST_BITS,
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [EW-1:0]               i_waddr,
    input  logic [VTX_BITS-1:0]         i_wtail,
    input  logic [VTX_BITS-1:0]         i_whead,
    input  logic signed [COST_BITS-1:0] i_wcost,
    input  logic                        i_re,
    input  logic [EW-1:0]               i_raddr,
    output logic [VTX_BITS-1:0]         o_tail,
    output logic [VTX_BITS-1:0]         o_head,
    output logic signed [COST_BITS-1:0] o_cost
);
    localparam int DW = 2 * VTX_BITS + COST_BITS;

    logic [DW-1:0] r_mem [MAX_EDGES];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wtail, i_whead, i_wcost};
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_tail = r_rdata[DW-1 -: VTX_BITS];
    assign o_head = r_rdata[COST_BITS +: VTX_BITS];
    assign o_cost = signed'(r_rdata[COST_BITS-1:0]);
endmodule

/* rtl/core/ncrm_dist_mem.sv */
`timescale 1ns / 1ps
module ncrm_dist_mem
    import ncrm_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int VW = $clog2(MAX_VERTICES)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [VW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic               i_re_a,
    input  logic [VW-1:0]      i_addr_a,
    output logic signed [31:0] o_data_a,
    input  logic               i_re_b,
    input  logic [VW-1:0]      i_addr_b,
    output logic signed [31:0] o_data_b
);
    logic signed [31:0] r_mem [MAX_VERTICES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_data_a <= r_mem[i_addr_a];
        end
        if (i_re_b) begin
            o_data_b <= r_mem[i_addr_b];
        end
    end
endmodule

/* dv/negative_cycle_reach_marking_top_tb.sv */
`timescale 1ns / 1ps
module negative_cycle_reach_marking_top_tb;
    import ncrm_pkg::*;

    localparam int NV = DEF_MAX_VERTICES;
    localparam int NE = DEF_MAX_EDGES;
    localparam int SETTLE = 40;

    typedef struct {
        t_kind           kind;
        logic [5:0]      from_v;
        logic [5:0]      to_v;
        logic signed [15:0] cost;
        logic [5:0]      query;
    } t_beat;

    typedef struct {
        logic               kind;
        logic               cycle;
        logic               dropped;
        logic signed [31:0] dval;
        logic               reach;
        logic               aff;
    } t_report;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_kind = '0;
    logic [5:0]               i_from_vertex = '0;
    logic [5:0]               i_to_vertex = '0;
    logic signed [15:0]       i_edge_cost = '0;
    logic [5:0]               i_query_vertex = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_result_kind;
    logic                     o_cycle_found;
    logic                     o_edges_dropped;
    logic signed [31:0]       o_distance;
    logic                     o_reachable;
    logic                     o_affected;

    negative_cycle_reach_marking_top DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the search block
    logic [5:0]         sh_tail [NE];
    logic [5:0]         sh_head [NE];
    logic signed [15:0] sh_cost [NE];
    int unsigned        sh_edges;
    logic signed [31:0] sh_dist [NV];
    bit                 sh_reached [NV];
    bit                 sh_aff [NV];
    bit                 sh_cycle;
    bit                 sh_overflow;
    logic [6:0]         sh_nv;
    logic [5:0]         sh_src;

    t_beat   stim_q[$];
    t_report expected_reports[$];
    int      errors = 0;
    bit      no_gaps = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit relax_pass(input int n, input bit mark);
        bit     changed;
        int     f;
        int     t;
        longint sum;
        logic signed [31:0] cand;
        changed = 0;
        for (int i = 0; i < sh_edges; i++) begin
            f = sh_tail[i];
            t = sh_head[i];
            if (f >= n || t >= n || !sh_reached[f]) continue;
            sum = longint'(sh_dist[f]) + longint'(sh_cost[i]);
            if (sum < -64'sd2147483648) cand = 32'sh80000000;
            else if (sum > 64'sd2147483647) cand = 32'sh7fffffff;
            else cand = sum[31:0];
            if (!sh_reached[t] || cand < sh_dist[t]) begin
                sh_dist[t] = cand;
                sh_reached[t] = 1;
                changed = 1;
                if (mark) sh_aff[t] = 1;
            end
            if (mark && sh_aff[f]) sh_aff[t] = 1;
        end
        return changed;
    endfunction

    function automatic void search_paths();
        int n;
        int passes;
        n = sh_nv;
        if (n < 1) n = 1;
        if (n > NV) n = NV;
        for (int v = 0; v < NV; v++) begin
            sh_dist[v] = 0;
            sh_reached[v] = 0;
            sh_aff[v] = 0;
        end
        sh_cycle = 0;
        if (sh_src >= n) return;
        sh_reached[sh_src] = 1;
        passes = 0;
        while (passes < n) begin
            if (!relax_pass(n, 0)) break;
            passes++;
        end
        if (passes != n) return;
        sh_cycle = 1;
        for (int k = 0; k < n; k++) void'(relax_pass(n, 1));
    endfunction

    function automatic void predict_beat(input t_beat b);
        t_report r;
        case (b.kind)
            K_ADD: begin
                if (sh_edges < NE) begin
                    sh_tail[sh_edges] = b.from_v;
                    sh_head[sh_edges] = b.to_v;
                    sh_cost[sh_edges] = b.cost;
                    sh_edges++;
                end else begin
                    sh_overflow = 1;
                end
            end
            K_CLEAR: begin
                sh_edges = 0;
                sh_overflow = 0;
            end
            default: begin
                if (b.kind == K_RUN) search_paths();
                r.kind = (b.kind == K_READ) ? RES_READ : RES_RUN;
                r.cycle = sh_cycle;
                r.dropped = sh_overflow;
                r.dval = 0;
                r.reach = 0;
                r.aff = 0;
                if (b.kind == K_READ) begin
                    if (sh_reached[b.query]) begin
                        r.dval = sh_dist[b.query];
                        r.reach = 1;
                    end
                    r.aff = sh_aff[b.query];
                end
                expected_reports = {expected_reports, r};
            end
        endcase
    endfunction

    // input driver
    t_beat cur;
    int    in_gap = 0;
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_beat(cur);
                busy = 0;
            end
            if (!busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    cur = stim_q.pop_front();
                    i_kind <= cur.kind;
                    i_from_vertex <= cur.from_v;
                    i_to_vertex <= cur.to_v;
                    i_edge_cost <= cur.cost;
                    i_query_vertex <= cur.query;
                    i_in_valid <= 1'b1;
                    in_gap = no_gaps ? 0 : $urandom_range(0, 5);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    int out_hold = 0;
    always @(posedge i_clk) begin
        t_report e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_reports.pop_front();
                    if (o_result_kind !== e.kind)
                        report_mismatch($sformatf("result_kind %b exp %b", o_result_kind, e.kind));
                    if (o_cycle_found !== e.cycle)
                        report_mismatch($sformatf("cycle_found %b exp %b", o_cycle_found, e.cycle));
                    if (o_edges_dropped !== e.dropped)
                        report_mismatch($sformatf("edges_dropped %b exp %b",
                                                  o_edges_dropped, e.dropped));
                    if (o_distance !== e.dval)
                        report_mismatch($sformatf("distance %0d exp %0d", o_distance, e.dval));
                    if (o_reachable !== e.reach)
                        report_mismatch($sformatf("reachable %b exp %b", o_reachable, e.reach));
                    if (o_affected !== e.aff)
                        report_mismatch($sformatf("affected %b exp %b", o_affected, e.aff));
                end
                out_hold = no_gaps ? 0 : $urandom_range(0, 5);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_beat(input t_kind k, input int f, input int t, input int c, input int q);
        t_beat b;
        b.kind = k;
        b.from_v = f[5:0];
        b.to_v = t[5:0];
        b.cost = c[15:0];
        b.query = q[5:0];
        stim_q = {stim_q, b};
    endtask

    task automatic push_rand(input t_kind k);
        push_beat(k, $urandom, $urandom, $urandom, $urandom);
    endtask

    // wait until the block has nothing left to do; sample after the edge has settled
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (stim_q.size() != 0 || i_in_valid || expected_reports.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[CFG_DATA_BITS-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_VERTEX_COUNT) sh_nv = val[6:0];
        else if (idx == CFG_SOURCE) sh_src = val[5:0];
    endtask

    initial begin
        int nv;
        int ne;
        int span;
        sh_edges = 0;
        sh_cycle = 0;
        sh_overflow = 0;
        sh_nv = 1;
        sh_src = 0;
        for (int v = 0; v < NV; v++) begin
            sh_dist[v] = 0;
            sh_reached[v] = 0;
            sh_aff[v] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values, one vertex, negative self loop
        push_rand(K_READ);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 0);
        push_beat(K_ADD, 0, 0, -1, 0);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 0);
        push_beat(K_READ, 0, 0, 0, 63);
        drain();
        write_reg(CFG_VERTEX_COUNT, 0);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 0);
        push_rand(K_CLEAR);
        drain();
        // count above the maximum, source at the top
        write_reg(CFG_VERTEX_COUNT, 127);
        write_reg(CFG_SOURCE, 63);
        push_beat(K_ADD, 63, 0, 32767, 0);
        push_beat(K_ADD, 0, 62, -32768, 0);
        push_beat(K_ADD, 62, 1, 0, 0);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 0);
        push_beat(K_READ, 0, 0, 0, 62);
        push_beat(K_READ, 0, 0, 0, 1);
        drain();
        // source beyond the count, endpoints beyond the count
        write_reg(CFG_VERTEX_COUNT, 3);
        write_reg(CFG_SOURCE, 5);
        write_reg(2, 9);
        write_reg(3, 127);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 5);
        drain();
        write_reg(CFG_SOURCE, 0);
        push_beat(K_ADD, 0, 2, 4, 0);
        push_beat(K_ADD, 0, 7, 4, 0);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 2);
        push_beat(K_READ, 0, 0, 0, 7);
        drain();

        // full store: two adds too many, then clear
        write_reg(CFG_VERTEX_COUNT, 2);
        push_rand(K_CLEAR);
        for (int i = 0; i < NE + 2; i++)
            push_beat(K_ADD, $urandom_range(0, 2), $urandom_range(0, 2),
                      $urandom_range(0, 9), 0);
        push_rand(K_RUN);
        push_beat(K_READ, 0, 0, 0, 1);
        push_rand(K_CLEAR);
        push_rand(K_READ);
        drain();

        // random graphs
        for (int s = 0; s < 6; s++) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 127) : $urandom_range(1, 12);
            write_reg(CFG_VERTEX_COUNT, nv);
            span = (nv > NV) ? NV : (nv < 1 ? 1 : nv);
            write_reg(CFG_SOURCE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                              : $urandom_range(0, span - 1));
            if ($urandom_range(0, 5) != 0) push_rand(K_CLEAR);
            ne = (nv > 16) ? $urandom_range(0, 8) : $urandom_range(0, 14);
            for (int i = 0; i < ne; i++) begin
                case ($urandom_range(0, 9))
                    0: push_rand(K_ADD);
                    1: push_beat(K_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
                                 $urandom_range(0, 65535), 0);
                    default: push_beat(K_ADD, $urandom_range(0, span - 1),
                                       $urandom_range(0, span - 1),
                                       $urandom_range(0, 30) - 6, $urandom);
                endcase
            end
            push_rand(K_RUN);
            for (int i = 0; i < span + 2; i++)
                push_beat(K_READ, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, span - 1));
            if ($urandom_range(0, 3) == 0) begin
                push_rand(K_ADD);
                push_rand(K_READ);
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ncrm_pkg.sv
rtl/core/ncrm_edge_mem.sv
rtl/core/ncrm_dist_mem.sv
rtl/core/negative_cycle_reach_marking_top.sv
dv/negative_cycle_reach_marking_top_tb.sv
